[sv/fpm_pkg.sv]
package fpm_pkg;

	localparam int WINDOW_DEPTH_DEF = 100;
	localparam int MAX_STEPS_DEF = 255;
	localparam longint RATE_SCALE = 64'd256000000;
	localparam longint PERIOD_MAX = 64'hFFFFFF;
	localparam int STEP_RESET = 16667;

	typedef enum logic [1:0] {
		DIV_RATE_NOW,
		DIV_RATE_AVG,
		DIV_STEPS
	} div_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIV_SEL,
		ST_DIV_RUN,
		ST_EXTREMES,
		ST_FINISH
	} ctl_state_t;

	typedef struct packed {
		logic    accept;
		logic    read;
		logic    update;
		logic    div_load;
		logic    div_store;
		div_op_t div_op;
		logic    extremes;
		logic    load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic p_zero;
		logic sum_zero;
		logic step_zero;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

[sv/fpm_div.sv]
module fpm_div import fpm_pkg::*; #(
	parameter int NUM_W = 35,
	parameter int DVS_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [NUM_W-1:0] quotient
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] den_q;
	logic [NUM_W-1:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign fits = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			num_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DVS_W'(trial - {1'b0, den_q}) : DVS_W'(trial);
			num_q <= {num_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = num_q;

endmodule

[sv/fpm_datapath.sv]
module fpm_datapath import fpm_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_cmd_t    cmd,
	output dp_status_t  status,
	input  logic        cfg_valid,
	input  logic [19:0] step_period_us,
	input  logic [23:0] period_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [27:0] rate_now,
	output logic [27:0] rate_average,
	output logic [27:0] rate_least,
	output logic [27:0] rate_greatest,
	output logic [23:0] period_average,
	output logic [23:0] period_least,
	output logic [23:0] period_greatest,
	output logic [31:0] frames_seen,
	output logic [47:0] time_elapsed_us,
	output logic [7:0]  steps_due,
	output logic [47:0] simulated_time_us
);

	localparam int     PTR_W = $clog2(WINDOW_DEPTH);
	localparam longint AVG_NUM = longint'(WINDOW_DEPTH) * RATE_SCALE;
	localparam int     NUM_RAW = $clog2(AVG_NUM + 1);
	localparam int     SUM_W = $clog2(longint'(WINDOW_DEPTH) * PERIOD_MAX + 1);
	localparam int     NUM_A = (NUM_RAW > SUM_W) ? NUM_RAW : SUM_W;
	localparam int     NUM_W = (NUM_A > 32) ? NUM_A : 32;
	localparam int     DVS_W = (SUM_W > 32) ? SUM_W : 32;
	localparam int     RCP_SH = SUM_W + $clog2(WINDOW_DEPTH);
	localparam int     PROD_W = 2 * SUM_W + 1;
	localparam longint RCP_MUL = ((longint'(1) << RCP_SH) + longint'(WINDOW_DEPTH) - 1)
		/ longint'(WINDOW_DEPTH);

	logic [23:0]      ring_mem [WINDOW_DEPTH];
	logic [23:0]      rd_q;
	logic [PTR_W-1:0] ptr_q;
	logic             wrapped_q;
	logic [23:0]      p_q;
	logic [19:0]      step_q;
	logic [SUM_W-1:0] sum_q;
	logic [31:0]      acc_q;
	logic [27:0]      rate_now_q;
	logic [27:0]      rate_avg_q;
	logic [27:0]      rate_min_q;
	logic [27:0]      rate_max_q;
	logic [23:0]      pavg_q;
	logic [23:0]      pmin_q;
	logic [23:0]      pmax_q;
	logic [31:0]      frames_q;
	logic [47:0]      elapsed_q;
	logic [47:0]      sim_q;
	logic [7:0]       steps_q;
	logic             out_valid_q;

	logic [23:0]       old_p;
	logic [32:0]       acc_sum;
	logic [NUM_W-1:0]  div_num;
	logic [DVS_W-1:0]  div_den;
	logic [NUM_W-1:0]  quo;
	logic              div_done;
	logic [7:0]        steps_sat;
	logic [27:0]       step_prod;
	logic [PROD_W-1:0] pavg_prod;

	assign old_p = wrapped_q ? rd_q : 24'd0;
	assign acc_sum = {1'b0, acc_q} + 33'(p_q);
	assign steps_sat = (quo > NUM_W'(MAX_STEPS)) ? 8'(MAX_STEPS) : quo[7:0];
	assign step_prod = 28'(steps_sat) * 28'(step_q);
	assign pavg_prod = PROD_W'(sum_q) * PROD_W'(RCP_MUL);

	always_comb begin
		unique case (cmd.div_op)
			DIV_RATE_NOW: begin
				div_num = NUM_W'(RATE_SCALE);
				div_den = DVS_W'(p_q);
			end
			DIV_RATE_AVG: begin
				div_num = NUM_W'(AVG_NUM);
				div_den = DVS_W'(sum_q);
			end
			default: begin
				div_num = NUM_W'(acc_q);
				div_den = DVS_W'(step_q);
			end
		endcase
	end

	fpm_div #(
		.NUM_W(NUM_W),
		.DVS_W(DVS_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_load),
		.dividend(div_num),
		.divisor(div_den),
		.done(div_done),
		.quotient(quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.read)
			rd_q <= ring_mem[ptr_q];
		if (cmd.update)
			ring_mem[ptr_q] <= p_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			p_q <= period_us;
		if (cmd.load_out) begin
			rate_now <= rate_now_q;
			rate_average <= rate_avg_q;
			rate_least <= rate_min_q;
			rate_greatest <= rate_max_q;
			period_average <= pavg_q;
			period_least <= pmin_q;
			period_greatest <= pmax_q;
			frames_seen <= frames_q;
			time_elapsed_us <= elapsed_q;
			steps_due <= steps_q;
			simulated_time_us <= sim_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			wrapped_q <= 1'b0;
			step_q <= 20'(STEP_RESET);
			sum_q <= '0;
			acc_q <= '0;
			rate_now_q <= '0;
			rate_avg_q <= '0;
			rate_min_q <= '1;
			rate_max_q <= '0;
			pavg_q <= '0;
			pmin_q <= '1;
			pmax_q <= '0;
			frames_q <= '0;
			elapsed_q <= '0;
			sim_q <= '0;
			steps_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid)
				step_q <= step_period_us;
			if (cmd.update) begin
				sum_q <= sum_q - SUM_W'(old_p) + SUM_W'(p_q);
				if (ptr_q == PTR_W'(WINDOW_DEPTH - 1)) begin
					ptr_q <= '0;
					wrapped_q <= 1'b1;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
				elapsed_q <= elapsed_q + 48'(p_q);
				acc_q <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
				frames_q <= frames_q + 1'b1;
				if (p_q < pmin_q)
					pmin_q <= p_q;
				if (p_q > pmax_q)
					pmax_q <= p_q;
				steps_q <= '0;
			end
			if (cmd.div_store) begin
				unique case (cmd.div_op)
					DIV_RATE_NOW: rate_now_q <= quo[27:0];
					DIV_RATE_AVG: begin
						rate_avg_q <= (quo > NUM_W'(RATE_SCALE)) ? 28'(RATE_SCALE) : quo[27:0];
					end
					default: begin
						steps_q <= steps_sat;
						acc_q <= acc_q - 32'(step_prod);
						sim_q <= sim_q + 48'(step_prod);
					end
				endcase
			end
			if (cmd.extremes) begin
				if (rate_now_q < rate_min_q)
					rate_min_q <= rate_now_q;
				if (rate_now_q > rate_max_q)
					rate_max_q <= rate_now_q;
				pavg_q <= pavg_prod[RCP_SH +: 24];
			end
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status.p_zero = (p_q == 24'd0);
	assign status.sum_zero = (sum_q == '0);
	assign status.step_zero = (step_q == 20'd0);
	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || !out_stall;

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(WINDOW_DEPTH - 1))
		else $error("ring pointer past window");
	a_steps_cap: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= 8'(MAX_STEPS))
		else $error("steps above cap");
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result overwritten before transaction");
	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("result not presented");

endmodule

[sv/fpm_ctrl.sv]
module fpm_ctrl import fpm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;
	div_op_t    op_q, op_d, op_next;
	logic       skip;
	logic       last;

	always_comb begin
		unique case (op_q)
			DIV_RATE_NOW:   op_next = DIV_RATE_AVG;
			DIV_RATE_AVG:   op_next = DIV_STEPS;
			default:        op_next = DIV_RATE_NOW;
		endcase
	end

	assign last = (op_q == DIV_STEPS);
	assign skip = (op_q == DIV_RATE_NOW && status.p_zero)
		|| (op_q == DIV_RATE_AVG && status.sum_zero)
		|| (op_q == DIV_STEPS && status.step_zero);

	always_comb begin
		state_d = state_q;
		op_d = op_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_READ;
			ST_READ: state_d = ST_UPDATE;
			ST_UPDATE: begin
				state_d = ST_DIV_SEL;
				op_d = DIV_RATE_NOW;
			end
			ST_DIV_SEL: begin
				if (!skip) begin
					state_d = ST_DIV_RUN;
				end else begin
					op_d = op_next;
					if (last)
						state_d = ST_EXTREMES;
				end
			end
			ST_DIV_RUN: begin
				if (status.div_done) begin
					op_d = op_next;
					state_d = last ? ST_EXTREMES : ST_DIV_SEL;
				end
			end
			ST_EXTREMES: state_d = ST_FINISH;
			ST_FINISH: if (status.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.div_op = op_q;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE:     cmd.accept = in_valid;
			ST_READ:     cmd.read = 1'b1;
			ST_UPDATE:   cmd.update = 1'b1;
			ST_DIV_SEL:  cmd.div_load = !skip;
			ST_DIV_RUN:  cmd.div_store = status.div_done;
			ST_EXTREMES: cmd.extremes = 1'b1;
			ST_FINISH:   cmd.load_out = status.out_free;
			default:     cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= DIV_RATE_NOW;
		end else begin
			state_q <= state_d;
			op_q <= op_d;
		end
	end

	a_store_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_store |-> $past(state_q == ST_DIV_RUN || state_q == ST_DIV_SEL))
		else $error("quotient stored outside a divide");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> state_q == ST_READ)
		else $error("transaction accepted without start");
	a_load_after_ext: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.extremes |=> state_q == ST_FINISH)
		else $error("extremes not followed by finish");

endmodule

[sv/frame_period_monitor_fixed_step.sv]
// channel  | handshake            | payload
// cfg      | cfg_valid/cfg_ready  | step_period_us
// in       | in_valid/in_stall    | period_us
// out      | out_valid/out_stall  | rate_*, period_*, frames_seen, time_elapsed_us, ...
// One transaction at a time; in_stall is high outside the idle state.
// The shared divider retires one quotient bit per cycle; skipped divides do not start it.
// The period average is a constant reciprocal product taken in the extremes cycle.
// Reset zeroes counters and maxima, sets minima to all ones; ring needs no clearing.
// The next transaction is accepted while the previous result waits on out_stall.
module frame_period_monitor_fixed_step import fpm_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF,
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [19:0] step_period_us,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] period_us,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [27:0] rate_now,
	output logic [27:0] rate_average,
	output logic [27:0] rate_least,
	output logic [27:0] rate_greatest,
	output logic [23:0] period_average,
	output logic [23:0] period_least,
	output logic [23:0] period_greatest,
	output logic [31:0] frames_seen,
	output logic [47:0] time_elapsed_us,
	output logic [7:0]  steps_due,
	output logic [47:0] simulated_time_us
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	fpm_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status(status),
		.cmd(cmd)
	);

	fpm_datapath #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.MAX_STEPS(MAX_STEPS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.cfg_valid(cfg_valid),
		.step_period_us(step_period_us),
		.period_us(period_us),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rate_now(rate_now),
		.rate_average(rate_average),
		.rate_least(rate_least),
		.rate_greatest(rate_greatest),
		.period_average(period_average),
		.period_least(period_least),
		.period_greatest(period_greatest),
		.frames_seen(frames_seen),
		.time_elapsed_us(time_elapsed_us),
		.steps_due(steps_due),
		.simulated_time_us(simulated_time_us)
	);

endmodule
